// ----- rtl/hrfw_pkg.sv -----
// ============================================================================
// hrfw_pkg: shared types, constants and helpers of the hex record writer
// Character codes, the result word layout and the ASCII to nibble
// conversion used by the parser and the output buffer.
// ============================================================================
`default_nettype none

package hrfw_pkg;

   // Character codes that steer the parser.
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_FOUR  = 8'h34;

   // Offsets that turn a character into its nibble value.
   localparam logic [7:0] DIGIT_BIAS  = 8'd48;
   localparam logic [7:0] LETTER_BIAS = 8'd55;

   // Character position counter.
   localparam int unsigned POS_WIDTH = 10;
   localparam logic [POS_WIDTH-1:0] POS_MAX = 10'd1023;

   // One result word.
   typedef struct packed {
      logic [31:0] write_address;
      logic [15:0] write_data;
      logic        last_in_record;
   } result_type;

   // Decimal digits give their value; every other character gives the
   // character minus 55, of which only the low four bits are kept.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] diff;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - DIGIT_BIAS;
      end else begin
         diff = c - LETTER_BIAS;
      end
      return diff[3:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hrfw_parser.sv -----
// ============================================================================
// hrfw_parser: record parser of the hex record writer
// Tracks the record position, byte count, record type, base address and
// nibble accumulator, and forms one result word per completed data halfword.
// ============================================================================
`default_nettype none

module hrfw_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                char_accept,
   input  logic [7:0]          text_char,
   output logic                result_valid,
   output hrfw_pkg::result_type result
);

   localparam logic [hrfw_pkg::POS_WIDTH-1:0] POS_COUNT_HIGH = 10'd1;
   localparam logic [hrfw_pkg::POS_WIDTH-1:0] POS_COUNT_LOW  = 10'd2;
   localparam logic [hrfw_pkg::POS_WIDTH-1:0] POS_ADDR_FIRST = 10'd3;
   localparam logic [hrfw_pkg::POS_WIDTH-1:0] POS_ADDR_LAST  = 10'd6;
   localparam logic [hrfw_pkg::POS_WIDTH-1:0] POS_TYPE_HIGH  = 10'd7;
   localparam logic [hrfw_pkg::POS_WIDTH-1:0] POS_TYPE_LOW   = 10'd8;
   localparam logic [hrfw_pkg::POS_WIDTH-1:0] POS_FIRST_WORD = 10'd12;

   logic                            in_record_ff, in_record_in;
   logic [hrfw_pkg::POS_WIDTH-1:0]  char_position_ff, char_position_in;
   logic [7:0]                      byte_count_ff, byte_count_in;
   logic [7:0]                      type_char_ff, type_char_in;
   logic [31:0]                     base_address_ff, base_address_in;
   logic [15:0]                     nibble_accumulator_ff, nibble_accumulator_in;
   logic [6:0]                      halfword_index_ff, halfword_index_in;

   logic [hrfw_pkg::POS_WIDTH-1:0]  pos_next;
   logic [3:0]                      nib;
   logic [15:0]                     acc_shift;
   logic [6:0]                      halfword_count;
   logic                            group_end;

   always_comb begin
      in_record_in          = in_record_ff;
      char_position_in      = char_position_ff;
      byte_count_in         = byte_count_ff;
      type_char_in          = type_char_ff;
      base_address_in       = base_address_ff;
      nibble_accumulator_in = nibble_accumulator_ff;
      halfword_index_in     = halfword_index_ff;
      result_valid          = 1'b0;

      pos_next = (char_position_ff < hrfw_pkg::POS_MAX) ?
                 char_position_ff + 10'd1 : char_position_ff;
      nib            = hrfw_pkg::hex_nibble(text_char);
      acc_shift      = {nibble_accumulator_ff[11:0], nib};
      halfword_count = byte_count_ff[7:1];
      group_end      = (pos_next >= POS_FIRST_WORD) && (pos_next[1:0] == 2'd0) &&
                       (pos_next != hrfw_pkg::POS_MAX);

      result.write_address  = base_address_ff + {24'd0, halfword_index_ff, 1'b0};
      result.write_data     = acc_shift;
      result.last_in_record = (halfword_index_ff + 7'd1) == halfword_count;

      if (char_accept) begin
         if (text_char == hrfw_pkg::CHAR_COLON) begin
            // A colon opens a record; the base address survives it.
            in_record_in          = 1'b1;
            char_position_in      = '0;
            byte_count_in         = '0;
            type_char_in          = '0;
            nibble_accumulator_in = '0;
            halfword_index_in     = '0;
         end else if (in_record_ff) begin
            char_position_in = pos_next;
            priority if (pos_next == POS_COUNT_HIGH) begin
               byte_count_in = {nib, 4'h0};
            end else if (pos_next == POS_COUNT_LOW) begin
               byte_count_in = byte_count_ff | {4'h0, nib};
            end else if (pos_next >= POS_ADDR_FIRST && pos_next <= POS_ADDR_LAST) begin
               nibble_accumulator_in = acc_shift;
            end else if (pos_next == POS_TYPE_HIGH) begin
               char_position_in = pos_next;
            end else if (pos_next == POS_TYPE_LOW) begin
               type_char_in = text_char;
               if (text_char == hrfw_pkg::CHAR_ZERO) begin
                  base_address_in = {base_address_ff[31:16], nibble_accumulator_ff};
               end
            end else begin
               nibble_accumulator_in = acc_shift;
               if (group_end) begin
                  if (type_char_ff == hrfw_pkg::CHAR_FOUR) begin
                     if (pos_next == POS_FIRST_WORD) begin
                        base_address_in = {acc_shift, base_address_ff[15:0]};
                     end
                  end else if (type_char_ff == hrfw_pkg::CHAR_ZERO &&
                               halfword_index_ff < halfword_count) begin
                     result_valid      = 1'b1;
                     halfword_index_in = halfword_index_ff + 7'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_record_ff          <= 1'b0;
         char_position_ff      <= '0;
         byte_count_ff         <= '0;
         type_char_ff          <= '0;
         base_address_ff       <= '0;
         nibble_accumulator_ff <= '0;
         halfword_index_ff     <= '0;
      end else begin
         in_record_ff          <= in_record_in;
         char_position_ff      <= char_position_in;
         byte_count_ff         <= byte_count_in;
         type_char_ff          <= type_char_in;
         base_address_ff       <= base_address_in;
         nibble_accumulator_ff <= nibble_accumulator_in;
         halfword_index_ff     <= halfword_index_in;
      end
   end

   // A halfword is only produced inside a data record.
   a_emit_in_data_record: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (in_record_ff && type_char_ff == hrfw_pkg::CHAR_ZERO))
      else $error("halfword produced outside a data record");

   // Every produced halfword advances the index by exactly one.
   a_index_advances: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> (halfword_index_ff == $past(halfword_index_ff) + 7'd1))
      else $error("halfword index did not advance");

   // After the last halfword the index has reached the halfword count.
   a_last_reaches_count: assert property (@(posedge clock) disable iff (reset)
      (result_valid && result.last_in_record) |=>
         (halfword_index_ff == byte_count_ff[7:1]))
      else $error("last halfword flagged before the count was reached");

endmodule

`default_nettype wire

// ----- rtl/hrfw_out_skid.sv -----
// ============================================================================
// hrfw_out_skid: result register with skid stage
// Holds the result word for the receiver and catches one more word while
// the receiver stalls, so the input side never waits on a combinational path.
// ============================================================================
`default_nettype none

module hrfw_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hrfw_pkg::result_type in_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output hrfw_pkg::result_type out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   hrfw_pkg::result_type out_data_ff, out_data_in;
   hrfw_pkg::result_type skid_data_ff, skid_data_in;
   logic                 out_take;

   always_comb begin
      out_take      = out_valid_ff && !out_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // The skid stage only fills behind an occupied result register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a word while the result register is empty");

   // A word arriving while the receiver stalls lands in the skid stage.
   a_stalled_word_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stall && in_valid) |=> skid_valid_ff)
      else $error("word lost while the receiver stalled");

   // Once the receiver takes a word, the skid stage drains into the register.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid stage did not drain");

endmodule

`default_nettype wire

// ----- rtl/hex_record_flash_writer.sv -----
// ============================================================================
// hex_record_flash_writer: streaming hex record to flash halfword writer
// Parses hex record text character by character and issues one flash
// write word for every data halfword that completes.
// ============================================================================
// Usage
// The request channel (req_valid, req_stall, req_text_char) carries one
// ASCII character per word. A colon opens a record; text outside a record
// is dropped. The response channel (rsp_valid, rsp_stall, rsp_write_address,
// rsp_write_data, rsp_last_in_record) carries one word for each halfword of
// a data record, addressed at the base address plus twice its index.
// Extended address records update the upper half of the base address.
// A response word is registered once the character that completes its
// halfword is accepted. Throughput: one character per cycle while req_stall
// is low, set by the single registered update of the parser state.
// When the receiver stalls, the result register holds its word and a skid
// stage takes one more; only when that stage is also occupied does
// req_stall rise. Reset clears the parser state, the base address and both
// output stages; no response is pending afterwards.
// ============================================================================
`default_nettype none

module hex_record_flash_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_write_address,
   output logic [15:0] rsp_write_data,
   output logic        rsp_last_in_record
);

   logic                 char_accept;
   logic                 result_valid;
   hrfw_pkg::result_type result;
   hrfw_pkg::result_type rsp_data;
   logic                 skid_full;

   // A character is taken whenever the skid stage has room, so the input
   // side never sees the receiver's stall in the same cycle.
   assign req_stall   = skid_full;
   assign char_accept = req_valid && !skid_full;

   // Parser: all state updates for one character are registered together.
   hrfw_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .char_accept  (char_accept),
      .text_char    (req_text_char),
      .result_valid (result_valid),
      .result       (result)
   );

   // Result register plus one skid word towards the receiver.
   hrfw_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_data   (result),
      .full      (skid_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_write_address  = rsp_data.write_address;
   assign rsp_write_data     = rsp_data.write_data;
   assign rsp_last_in_record = rsp_data.last_in_record;

endmodule

`default_nettype wire

// ----- tb/hex_record_flash_writer_tb.sv -----
// ============================================================================
// hex_record_flash_writer_tb: self-checking bench for the hex record writer
// Feeds hex record text one character per word, predicts every flash write
// word with a behavioural parser of its own and checks each response word,
// field by field, in order. A short directed table comes first, followed by
// randomly composed records, noise and one very long line, while both
// channels idle and stall at random.
// ============================================================================

module hex_record_flash_writer_tb;

   import hrfw_pkg::*;

   // A directed row: one character and, where the write it causes can be
   // read straight off the record, the write word itself.
   typedef struct packed {
      logic [7:0] ch;
      logic       has_word;
      result_type word;
   } stim_row_t;

   // How the response side behaves for a stretch of cycles.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_t;

   localparam logic [7:0] CHAR_F       = 8'h46;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;

   localparam result_type NO_WORD = '0;

   localparam int CHAR_TARGET   = 1380;   // directed rows plus about 1350 random
   localparam int WRITE_TARGET  = 60;
   localparam int LONG_LINE_NO  = 6;      // which random record is the long line
   localparam int LONG_LINE_LEN = 1100;   // past the point where the position saturates
   localparam int HOLD_CYCLES   = 90;
   localparam int DRAIN_CYCLES  = 20;
   localparam int IDLE_LIMIT    = 2000;

   // The directed table. The first record has an odd byte count of three, so
   // only one halfword is written and the trailing byte is dropped; its
   // address comes straight from the load address, since the base is zero
   // after reset. A colon then restarts the parser mid-record with an
   // extended address record, and the two extreme character codes trail it.
   localparam stim_row_t DIRECTED_ROWS [29] = '{
      '{"Z", 1'b0, NO_WORD},              // text before any colon is dropped
      '{":", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"3", 1'b0, NO_WORD},
      '{"F", 1'b0, NO_WORD},
      '{"F", 1'b0, NO_WORD},
      '{"F", 1'b0, NO_WORD},
      '{"F", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},              // data record type
      '{"F", 1'b0, NO_WORD},
      '{"F", 1'b0, NO_WORD},
      '{"F", 1'b0, NO_WORD},
      '{"F", 1'b1, '{32'h0000_FFFF, 16'hFFFF, 1'b1}},
      '{":", 1'b0, NO_WORD},              // colon inside a record
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"4", 1'b0, NO_WORD},              // extended address record type
      '{"8", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{"0", 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD}
   };

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_char      = '0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [31:0] rsp_write_address;
   logic [15:0] rsp_write_data;
   logic        rsp_last_in_record;

   // Side information that travels with the character on offer.
   logic        feed_has_word = 1'b0;
   result_type  feed_word     = NO_WORD;

   // Handshake flags, written at the rising edge and read at the falling one.
   bit          char_taken;
   bit          word_taken;

   bit          long_line_begun;
   bit          hold_done;
   bit          draining;
   int          chars_sent;
   int          writes_predicted;
   int          failures;
   int          idle_cycles;
   int          burst_left;
   logic [7:0]  line_text [$];
   result_type  pending_writes [$];

   // The parser as this bench sees it.
   logic        parsing;
   logic [9:0]  char_pos;
   logic [7:0]  rec_bytes;
   logic [7:0]  rec_type;
   logic [31:0] flash_base;
   logic [15:0] nibble_acc;
   logic [6:0]  halfword_count;

   hex_record_flash_writer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_char      (req_text_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_data     (rsp_write_data),
      .rsp_last_in_record (rsp_last_in_record)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Decimal digits map to their value. Anything else is taken as a letter,
   // so that 'A' gives ten, and only the low four bits survive; lower-case
   // letters therefore land on the same values as upper-case ones.
   function automatic logic [3:0] char_value(input logic [7:0] c);
      logic [7:0] offset;
      offset = (c >= CHAR_ZERO && c <= CHAR_NINE) ? DIGIT_BIAS : LETTER_BIAS;
      return 4'(c - offset);
   endfunction

   // A colon clears everything that belongs to one record. The flash base
   // is deliberately left alone, as it spans records.
   task automatic clear_record();
      char_pos       = '0;
      rec_bytes      = '0;
      rec_type       = '0;
      nibble_acc     = '0;
      halfword_count = '0;
   endtask

   task automatic advance_parser(input logic [7:0] c, output bit produced,
                                 output result_type word);
      logic [3:0] n;
      produced = 1'b0;
      word     = NO_WORD;
      if (c == CHAR_COLON) begin
         parsing = 1'b1;
         clear_record();
      end else if (parsing) begin
         // The position sticks at its maximum on very long lines.
         if (char_pos != POS_MAX) begin
            char_pos = char_pos + 10'd1;
         end
         n = char_value(c);
         if (char_pos == 10'd1) begin
            rec_bytes = {n, 4'h0};
         end else if (char_pos == 10'd2) begin
            rec_bytes[3:0] = n;
         end else if (char_pos <= 10'd6) begin
            nibble_acc = {nibble_acc[11:0], n};
         end else if (char_pos == 10'd8) begin
            // Only the low type digit is looked at. A data record moves its
            // load address into the low half of the base straight away.
            rec_type = c;
            if (c == CHAR_ZERO) begin
               flash_base[15:0] = nibble_acc;
            end
         end else if (char_pos >= 10'd9) begin
            nibble_acc = {nibble_acc[11:0], n};
            // A group of four closes at every position that is a multiple of
            // four, from twelve onwards.
            if (char_pos >= 10'd12 && char_pos[1:0] == 2'b00 && char_pos != POS_MAX) begin
               if (rec_type == CHAR_FOUR) begin
                  if (char_pos == 10'd12) begin
                     flash_base[31:16] = nibble_acc;
                  end
               end else if (rec_type == CHAR_ZERO && halfword_count < rec_bytes[7:1]) begin
                  produced            = 1'b1;
                  word.write_address  = flash_base + {24'd0, halfword_count, 1'b0};
                  word.write_data     = nibble_acc;
                  word.last_in_record = ({1'b0, halfword_count} + 8'd1
                                         == {1'b0, rec_bytes[7:1]});
                  halfword_count      = halfword_count + 7'd1;
               end
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: both channels are sampled at the rising edge. A character
   // accepted here is run through the parser at once; a response word
   // accepted here is checked against the oldest write still awaited.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : port_monitor
      bit         produced;
      result_type predicted;
      result_type wanted;
      if (reset) begin
         parsing    = 1'b0;
         flash_base = '0;
         clear_record();
         pending_writes.delete();
         char_taken  = 1'b0;
         word_taken  = 1'b0;
         idle_cycles = 0;
      end else begin
         char_taken = req_valid && !req_stall;
         word_taken = rsp_valid && !rsp_stall;
         if (char_taken) begin
            advance_parser(req_text_char, produced, predicted);
            if (feed_has_word) begin
               pending_writes.push_back(feed_word);
            end else if (produced) begin
               pending_writes.push_back(predicted);
            end
            if (feed_has_word || produced) begin
               writes_predicted++;
            end
         end
         if (word_taken) begin
            if (pending_writes.size() == 0) begin
               $error("unexpected write word: address %h, data %h, last %b",
                      rsp_write_address, rsp_write_data, rsp_last_in_record);
               failures++;
            end else begin
               wanted = pending_writes.pop_front();
               if (rsp_write_address !== wanted.write_address) begin
                  $error("write_address: expected %h, got %h",
                         wanted.write_address, rsp_write_address);
                  failures++;
               end
               if (rsp_write_data !== wanted.write_data) begin
                  $error("write_data: expected %h, got %h",
                         wanted.write_data, rsp_write_data);
                  failures++;
               end
               if (rsp_last_in_record !== wanted.last_in_record) begin
                  $error("last_in_record: expected %b, got %b",
                         wanted.last_in_record, rsp_last_in_record);
                  failures++;
               end
            end
         end
         // Watchdog: a long run of cycles with no word moving on either side
         // means the block has hung or is holding back a write.
         if (char_taken || word_taken) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("hex_record_flash_writer test failed");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? CHAR_ZERO + 8'(v) : CHAR_UPPER_A + 8'(v) - 8'd10;
   endfunction

   // Any character code at all, except the colon that would restart parsing.
   function automatic logic [7:0] text_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      return (c == CHAR_COLON) ? CHAR_SEMI : c;
   endfunction

   // Mostly proper upper-case hex, now and then lower case or plain junk.
   function automatic logic [7:0] loose_hex();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         return text_byte();
      end
      if (pick < 12) begin
         return CHAR_LOWER_A + 8'($urandom_range(0, 5));
      end
      return hex_digit(4'($urandom_range(0, 15)));
   endfunction

   // Builds one line of text in line_text. Most lines are well-formed data
   // or extended address records with random content, so that the parser
   // gets deep into its positions; the rest are other record types, stray
   // text, bare colons with a little text behind them, and records cut
   // short. All-F addresses and data push the base and the write address
   // round through the top of the address space.
   task automatic compose_record(input bit long_line);
      int         kind;
      int         n;
      bit         all_f;
      logic [7:0] count;
      logic [7:0] rtype;
      line_text = {};
      kind = long_line ? 30 : $urandom_range(0, 99);
      if (kind < 10) begin
         n = $urandom_range(1, 12);
         repeat (n) line_text.push_back(8'($urandom_range(0, 255)));
         return;
      end
      line_text.push_back(CHAR_COLON);
      if (kind < 20) begin
         n = $urandom_range(0, 14);
         repeat (n) line_text.push_back(loose_hex());
         return;
      end
      all_f = ($urandom_range(0, 4) == 0);
      if (long_line) begin
         count = 8'hFF;
         rtype = CHAR_ZERO;
      end else if (kind < 62) begin
         count = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 48))
                                               : 8'($urandom_range(0, 12));
         rtype = CHAR_ZERO;
      end else if (kind < 80) begin
         count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 3)) : 8'd2;
         rtype = CHAR_FOUR;
      end else begin
         count = 8'($urandom_range(0, 8));
         do rtype = loose_hex(); while (rtype == CHAR_ZERO || rtype == CHAR_FOUR);
      end
      line_text.push_back(hex_digit(count[7:4]));
      line_text.push_back(hex_digit(count[3:0]));
      repeat (4) line_text.push_back(all_f ? CHAR_F : loose_hex());
      line_text.push_back(($urandom_range(0, 9) == 0) ? loose_hex() : CHAR_ZERO);
      line_text.push_back(rtype);
      n = 2 * count;
      repeat (n) line_text.push_back(all_f ? CHAR_F : loose_hex());
      if (long_line) begin
         // Run well past the point where the position counter saturates.
         while (line_text.size() < LONG_LINE_LEN) line_text.push_back(text_byte());
         return;
      end
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, line_text.size() - 1);
         repeat (n) void'(line_text.pop_back());
         return;
      end
      // Checksum and line end; the parser must ignore all of it.
      line_text.push_back(loose_hex());
      line_text.push_back(loose_hex());
      if ($urandom_range(0, 1) == 0) begin
         line_text.push_back(CHAR_CR);
      end
      line_text.push_back(CHAR_LF);
   endtask

   // Offers one character word, starting and ending at a falling edge. The
   // sender works in bursts; between bursts valid may drop for a random gap.
   // Some bursts are long, which gives stretches with no idling at all.
   task automatic offer_char(input logic [7:0] c, input logic has_word,
                             input result_type word);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
      end
      req_valid     <= 1'b1;
      req_text_char <= c;
      feed_has_word <= has_word;
      feed_word     <= word;
      do @(negedge clock); while (!char_taken);
      burst_left--;
      chars_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall pattern of its own, switching between no stalls,
   // light and heavy stalling. Once the long line starts, the receiver holds
   // off for a long stretch so that both output stages fill and the block
   // has to stall its input while characters keep coming.
   // ---------------------------------------------------------------------
   initial begin : response_side
      stall_mode_t mode;
      int          mode_left;
      mode      = STALL_NONE;
      mode_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_line_begun && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (draining) begin
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_t'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 120);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:     rsp_stall <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int record_no;
      record_no = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         offer_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].has_word, DIRECTED_ROWS[i].word);
      end

      while (chars_sent < CHAR_TARGET || writes_predicted < WRITE_TARGET) begin
         compose_record(record_no == LONG_LINE_NO);
         if (record_no == LONG_LINE_NO) begin
            long_line_begun = 1'b1;
         end
         foreach (line_text[i]) begin
            offer_char(line_text[i], 1'b0, NO_WORD);
         end
         record_no++;
      end
      req_valid <= 1'b0;

      // Let the receiver take everything, then wait out the drain period so that
      // any stray write can show itself before the verdict.
      draining = 1'b1;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("hex_record_flash_writer test passed");
      end else begin
         $display("hex_record_flash_writer test failed");
      end
      $finish;
   end

endmodule
